FILE: sv/mmtt_pkg.sv
// ----------------------------------------------------------------------------
// mmtt_pkg
// Shared types and constants of the multichannel minute toggle timer.
// ----------------------------------------------------------------------------
package mmtt_pkg;

   localparam int OUT_W      = 16;
   localparam int DUR_W      = 16;
   localparam int PRESCALE_W = 16;
   localparam int PERIOD_W   = 8;
   localparam int CHAN_W     = 4;
   localparam int CSR_IDX_W  = 1;

   localparam logic [CSR_IDX_W-1:0] REG_PRESCALE_LIMIT     = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SECONDS_PER_PERIOD = 1'd1;

   localparam logic [PRESCALE_W-1:0] PRESCALE_RESET = 16'd30;
   localparam logic [PERIOD_W-1:0]   PERIOD_RESET   = 8'd60;

   localparam logic MODE_TICK  = 1'b0;
   localparam logic MODE_WRITE = 1'b1;

   localparam logic LEVEL_LOW  = 1'b0;
   localparam logic LEVEL_HIGH = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_WAIT
   } state_type;

endpackage

FILE: sv/multichannel_minute_toggle_timer.sv
// ----------------------------------------------------------------------------
// multichannel_minute_toggle_timer
// Prescaled tick counter driving a per-channel slow toggle timer whose
// counters and durations live in synchronous memories.
// Without a period end the result is registered directly, or via ST_WAIT if the output stalls.
// A period end sweeps all channels, one memory entry per cycle, in
// ST_SWEEP; the result is then registered from ST_WAIT.
// Throughput: one request per cycle without period end while the output is
// free; no request is taken during a sweep and the wait that follows it.
// Reset clears levels directly, and counters and tables at once through valid bits.
// ----------------------------------------------------------------------------
module multichannel_minute_toggle_timer
   import mmtt_pkg::*;
#(
   parameter int CHANNELS = 16
) (
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [23:0]           req_tdata,   // channel[3:0], duration[19:4], zero[23:20]
   input  logic [1:0]            req_tuser,   // mode[0], level_select[1]

   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [OUT_W-1:0]      rsp_tdata,   // outputs[15:0]
   output logic                  rsp_tuser,   // period_strobe[0]

   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [PRESCALE_W-1:0] csr_data
);

   localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int CNT_W = CH_W + 1;
   localparam int LW    = (CHANNELS > OUT_W) ? CHANNELS : OUT_W;

   logic [CHAN_W-1:0] req_channel;
   logic [DUR_W-1:0]  req_duration;
   logic              req_mode;
   logic              req_level_select;
   logic              req_fire;

   assign req_channel      = req_tdata[3:0];
   assign req_duration     = req_tdata[19:4];
   assign req_mode         = req_tuser[0];
   assign req_level_select = req_tuser[1];

   // configuration
   logic [PRESCALE_W-1:0] prescale_ff;
   logic [PERIOD_W-1:0]   period_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         prescale_ff <= PRESCALE_RESET;
         period_ff   <= PERIOD_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            REG_PRESCALE_LIMIT:     prescale_ff <= csr_data;
            REG_SECONDS_PER_PERIOD: period_ff   <= csr_data[PERIOD_W-1:0];
            default: ;
         endcase
      end
   end

   // control state
   state_type            state_ff, state_in;
   logic [PRESCALE_W-1:0] tick_ff, tick_in;
   logic [PERIOD_W-1:0]  sec_ff, sec_in;
   logic [CHANNELS-1:0]  level_ff, level_in;
   logic [CNT_W-1:0]     rd_cnt_ff, rd_cnt_in;
   logic                 proc_valid_ff;
   logic [CH_W-1:0]      proc_idx_ff;
   logic                 pend_strobe_ff, pend_strobe_in;
   logic                 rsp_valid_ff;
   logic [OUT_W-1:0]     rsp_out_ff;
   logic                 rsp_strobe_ff;

   // memories and their valid bits
   logic [DUR_W-1:0]    cnt_mem [CHANNELS];
   logic [2*DUR_W-1:0]  dur_mem [CHANNELS];
   logic [CHANNELS-1:0] cnt_vld_ff, dur_vld_lo_ff, dur_vld_hi_ff;
   logic [DUR_W-1:0]    cnt_rd_ff;
   logic [2*DUR_W-1:0]  dur_rd_ff;
   logic                rd_v_cnt_ff, rd_v_lo_ff, rd_v_hi_ff;

   // tick path
   logic [PRESCALE_W-1:0] tick_inc;
   logic [PERIOD_W-1:0]   sec_inc;
   logic                  second_end;
   logic                  period_end;

   assign tick_inc   = tick_ff + 1'b1;
   assign sec_inc    = sec_ff + 1'b1;
   assign second_end = tick_inc > prescale_ff;
   assign period_end = second_end && (sec_inc >= period_ff);

   // table write
   logic            dur_we_lo, dur_we_hi;
   logic [CH_W-1:0] wr_addr;

   assign wr_addr   = CH_W'(req_channel);
   assign dur_we_lo = req_fire && (req_mode == MODE_WRITE) &&
                      (32'(req_channel) < CHANNELS) && (req_level_select == LEVEL_LOW);
   assign dur_we_hi = req_fire && (req_mode == MODE_WRITE) &&
                      (32'(req_channel) < CHANNELS) && (req_level_select == LEVEL_HIGH);

   // sweep read side
   logic            rd_issue;
   logic [CH_W-1:0] rd_addr;

   assign rd_issue = (state_ff == ST_SWEEP) && (rd_cnt_ff != CNT_W'(CHANNELS));
   assign rd_addr  = rd_cnt_ff[CH_W-1:0];

   // sweep modify side
   logic [DUR_W-1:0] cnt_cur, dur_low, dur_high, cnt_new;
   logic             lvl_cur, toggle;

   always_comb begin
      cnt_cur  = rd_v_cnt_ff ? cnt_rd_ff : '0;
      dur_low  = rd_v_lo_ff ? dur_rd_ff[DUR_W-1:0] : '0;
      dur_high = rd_v_hi_ff ? dur_rd_ff[2*DUR_W-1:DUR_W] : '0;
      lvl_cur  = level_ff[proc_idx_ff];
      if (cnt_cur != '0) begin
         cnt_new = cnt_cur - 1'b1;
         toggle  = 1'b0;
      end else begin
         cnt_new = lvl_cur ? dur_low : dur_high;
         toggle  = 1'b1;
      end
      level_in = level_ff;
      if (proc_valid_ff && toggle) begin
         level_in[proc_idx_ff] = ~lvl_cur;
      end
   end

   // output register
   logic out_free;
   logic load_rsp;
   logic load_strobe;

   assign out_free = !rsp_valid_ff || rsp_tready;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      state_in       = state_ff;
      load_rsp       = 1'b0;
      load_strobe    = 1'b0;
      pend_strobe_in = pend_strobe_ff;
      tick_in        = tick_ff;
      sec_in         = sec_ff;
      rd_cnt_in      = rd_cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_mode == MODE_TICK) begin
                  tick_in = second_end ? '0 : tick_inc;
                  if (second_end) begin
                     sec_in = period_end ? '0 : sec_inc;
                  end
               end
               rd_cnt_in = '0;
               if ((req_mode == MODE_TICK) && period_end) begin
                  state_in       = ST_SWEEP;
                  pend_strobe_in = 1'b1;
               end else if (out_free) begin
                  load_rsp = 1'b1;
               end else begin
                  state_in       = ST_WAIT;
                  pend_strobe_in = 1'b0;
               end
            end
         end
         ST_SWEEP: begin
            if (rd_issue) begin
               rd_cnt_in = rd_cnt_ff + 1'b1;
            end else if (proc_valid_ff) begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (out_free) begin
               load_rsp    = 1'b1;
               load_strobe = pend_strobe_ff;
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         tick_ff        <= '0;
         sec_ff         <= '0;
         level_ff       <= '0;
         rd_cnt_ff      <= '0;
         proc_valid_ff  <= 1'b0;
         pend_strobe_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         cnt_vld_ff     <= '0;
         dur_vld_lo_ff  <= '0;
         dur_vld_hi_ff  <= '0;
      end else begin
         state_ff       <= state_in;
         tick_ff        <= tick_in;
         sec_ff         <= sec_in;
         level_ff       <= level_in;
         rd_cnt_ff      <= rd_cnt_in;
         proc_valid_ff  <= rd_issue;
         pend_strobe_ff <= pend_strobe_in;
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (proc_valid_ff) begin
            cnt_vld_ff[proc_idx_ff] <= 1'b1;
         end
         if (dur_we_lo) begin
            dur_vld_lo_ff[wr_addr] <= 1'b1;
         end
         if (dur_we_hi) begin
            dur_vld_hi_ff[wr_addr] <= 1'b1;
         end
      end
   end

   logic [LW-1:0] level_wide;
   assign level_wide = LW'(level_in);

   always_ff @(posedge clock) begin
      proc_idx_ff <= rd_addr;
      if (load_rsp) begin
         rsp_out_ff    <= level_wide[OUT_W-1:0];
         rsp_strobe_ff <= load_strobe;
      end
   end

   // counter memory
   always_ff @(posedge clock) begin
      if (proc_valid_ff) begin
         cnt_mem[proc_idx_ff] <= cnt_new;
      end
      if (rd_issue) begin
         cnt_rd_ff   <= cnt_mem[rd_addr];
         rd_v_cnt_ff <= cnt_vld_ff[rd_addr];
      end
   end

   // duration memory, low half and high half written separately
   always_ff @(posedge clock) begin
      if (dur_we_lo) begin
         dur_mem[wr_addr][DUR_W-1:0] <= req_duration;
      end
      if (dur_we_hi) begin
         dur_mem[wr_addr][2*DUR_W-1:DUR_W] <= req_duration;
      end
      if (rd_issue) begin
         dur_rd_ff  <= dur_mem[rd_addr];
         rd_v_lo_ff <= dur_vld_lo_ff[rd_addr];
         rd_v_hi_ff <= dur_vld_hi_ff[rd_addr];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_out_ff;
   assign rsp_tuser  = rsp_strobe_ff;

   // checks
   a_level_only_in_sweep: assert property (@(posedge clock) disable iff (reset)
      (level_ff != $past(level_ff)) |-> ($past(state_ff) == ST_SWEEP))
      else $error("channel levels changed outside a sweep");

   a_proc_in_sweep: assert property (@(posedge clock) disable iff (reset)
      proc_valid_ff |-> (state_ff == ST_SWEEP))
      else $error("channel update outside a sweep");

   a_strobe_after_sweep: assert property (@(posedge clock) disable iff (reset)
      (load_rsp && load_strobe) |-> (pend_strobe_ff && (state_ff == ST_WAIT)))
      else $error("period strobe without a finished sweep");

   a_sweep_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP) |-> (rd_cnt_ff <= CNT_W'(CHANNELS)))
      else $error("sweep index ran past the channel count");

endmodule
